@@ sv/saar_pkg.sv @@
// Shared constants and types for the SPI ADC averaging reader.
package saar_pkg;

    localparam int DATA_BITS_DEF  = 16;
    localparam int READS_LOG2_DEF = 3;

    localparam int CODE_W    = 16;
    localparam int HALF_W    = 8;
    localparam int DUMMY_W   = 3;
    localparam int CLK_CNT_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUMMY       = 1'd1;

    localparam logic [HALF_W-1:0]  HALF_RESET  = 8'd15;
    localparam logic [DUMMY_W-1:0] DUMMY_RESET = 3'd3;

    typedef struct packed {
        logic begin_meas;
        logic begin_conv;
        logic sample;
        logic conv_end;
        logic meas_end;
        logic cs_n;
        logic sclk;
        logic busy;
    } t_seq_ev;

endpackage

@@ sv/saar_if.sv @@
// Channel interfaces: tick input, result output and configuration write.
interface saar_in_if import saar_pkg::*; ();
    logic valid;
    logic ready;
    logic start_req;
    logic miso;
    modport source (output valid, output start_req, output miso, input ready);
    modport sink   (input valid, input start_req, input miso, output ready);
endinterface

interface saar_out_if import saar_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              chip_select_n;
    logic              serial_clock;
    logic              busy_res;
    logic              done_res;
    logic [CODE_W-1:0] average_code;
    logic [CODE_W-1:0] min_code;
    logic [CODE_W-1:0] max_code;
    modport source (output valid, output chip_select_n, output serial_clock,
                    output busy_res, output done_res, output average_code,
                    output min_code, output max_code, input ready);
    modport sink   (input valid, input chip_select_n, input serial_clock,
                    input busy_res, input done_res, input average_code,
                    input min_code, input max_code, output ready);
endinterface

interface saar_cfg_if import saar_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/saar_seq.sv @@
// Pin sequencer: phase timing, clock pulse and conversion counting.
module saar_seq import saar_pkg::*; #(
    parameter int DATA_BITS  = DATA_BITS_DEF,
    parameter int READS_LOG2 = READS_LOG2_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_start_req,
    input  logic [HALF_W-1:0]  i_half_period,
    input  logic [DUMMY_W-1:0] i_dummy,
    output t_seq_ev            o_ev
);

    typedef enum logic [1:0] {PH_IDLE, PH_LOW, PH_HIGH, PH_GAP} t_phase;

    localparam int RC_W = READS_LOG2 + 1;
    localparam logic [RC_W-1:0] READS_TOTAL = RC_W'(1 << READS_LOG2);
    localparam logic [CLK_CNT_W:0] DATA_BITS_C = (CLK_CNT_W + 1)'(DATA_BITS);

    t_phase               r_phase, n_phase;
    logic [HALF_W-1:0]    r_wait, n_wait;
    logic [CLK_CNT_W-1:0] r_cc, n_cc;
    logic [RC_W-1:0]      r_rc, n_rc;

    logic [HALF_W-1:0]  limit;
    logic [HALF_W:0]    wait_inc;
    logic               ph_end;
    logic [RC_W-1:0]    rc_inc;
    logic [CLK_CNT_W:0] conv_len;

    always_comb begin
        limit    = (i_half_period == '0) ? HALF_W'(1) : i_half_period;
        wait_inc = {1'b0, r_wait} + (HALF_W + 1)'(1);
        ph_end   = wait_inc >= {1'b0, limit};
        rc_inc   = r_rc + RC_W'(1);
        conv_len = {{(CLK_CNT_W + 1 - DUMMY_W){1'b0}}, i_dummy} + DATA_BITS_C;

        n_phase = r_phase;
        n_wait  = r_wait;
        n_cc    = r_cc;
        n_rc    = r_rc;
        o_ev    = '0;

        if (i_step) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_start_req) begin
                        o_ev.begin_meas = 1'b1;
                        o_ev.begin_conv = 1'b1;
                        n_phase = PH_LOW;
                        n_wait  = '0;
                        n_cc    = '0;
                        n_rc    = '0;
                    end
                end
                PH_LOW: begin
                    if (ph_end) begin
                        n_wait      = '0;
                        o_ev.sample = r_cc >= {{(CLK_CNT_W - DUMMY_W){1'b0}}, i_dummy};
                        n_phase     = PH_HIGH;
                    end else begin
                        n_wait = wait_inc[HALF_W-1:0];
                    end
                end
                PH_HIGH: begin
                    if (ph_end) begin
                        n_wait = '0;
                        n_cc   = r_cc + CLK_CNT_W'(1);
                        if ({1'b0, n_cc} >= conv_len) begin
                            o_ev.conv_end = 1'b1;
                            n_phase = PH_GAP;
                        end else begin
                            n_phase = PH_LOW;
                        end
                    end else begin
                        n_wait = wait_inc[HALF_W-1:0];
                    end
                end
                PH_GAP: begin
                    if (ph_end) begin
                        n_wait = '0;
                        if (rc_inc >= READS_TOTAL) begin
                            o_ev.meas_end = 1'b1;
                            n_rc    = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            o_ev.begin_conv = 1'b1;
                            n_rc    = rc_inc;
                            n_cc    = '0;
                            n_phase = PH_LOW;
                        end
                    end else begin
                        n_wait = wait_inc[HALF_W-1:0];
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        o_ev.cs_n = !(n_phase == PH_LOW || n_phase == PH_HIGH);
        o_ev.sclk = n_phase != PH_LOW;
        o_ev.busy = n_phase != PH_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wait  <= '0;
            r_cc    <= '0;
            r_rc    <= '0;
        end else begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_cc    <= n_cc;
            r_rc    <= n_rc;
        end
    end

endmodule

@@ sv/saar_stats.sv @@
// Data path: shift register, code sum, average and running min/max.
module saar_stats import saar_pkg::*; #(
    parameter int DATA_BITS  = DATA_BITS_DEF,
    parameter int READS_LOG2 = READS_LOG2_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_seq_ev              i_ev,
    input  logic                 i_miso,
    output logic [DATA_BITS-1:0] o_avg,
    output logic [DATA_BITS-1:0] o_min,
    output logic [DATA_BITS-1:0] o_max
);

    localparam int SUM_W = DATA_BITS + READS_LOG2;

    logic [DATA_BITS-1:0] r_shift, n_shift;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [DATA_BITS-1:0] r_avg, n_avg;
    logic [DATA_BITS-1:0] r_min, n_min;
    logic [DATA_BITS-1:0] r_max, n_max;
    logic [DATA_BITS-1:0] avg_calc;

    always_comb begin
        n_shift  = r_shift;
        n_sum    = r_sum;
        n_avg    = r_avg;
        n_min    = r_min;
        n_max    = r_max;
        avg_calc = r_sum[READS_LOG2 +: DATA_BITS];

        if (i_ev.begin_meas) begin
            n_sum = '0;
        end
        if (i_ev.begin_conv) begin
            n_shift = '0;
        end
        if (i_ev.sample) begin
            n_shift = {r_shift[DATA_BITS-2:0], i_miso};
        end
        if (i_ev.conv_end) begin
            n_sum = r_sum + {{READS_LOG2{1'b0}}, r_shift};
        end
        if (i_ev.meas_end) begin
            n_avg = avg_calc;
            if (avg_calc > r_max) begin
                n_max = avg_calc;
            end
            if (avg_calc < r_min) begin
                n_min = avg_calc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_sum   <= '0;
            r_avg   <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else begin
            r_shift <= n_shift;
            r_sum   <= n_sum;
            r_avg   <= n_avg;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    assign o_avg = n_avg;
    assign o_min = n_min;
    assign o_max = n_max;

endmodule

@@ sv/spi_adc_averaging_reader.sv @@
// Top level of the SPI ADC averaging reader: config, sequencer, stats, output register.
//
//  channel  | dir | transaction carries
//  i_in     | in  | one tick: start_req, miso
//  o_out    | out | pin levels, busy, done, average/min/max codes
//  i_cfg    | in  | register index and write data
//
// One tick is taken per clock cycle while o_out is not stalled; each tick's result is
// registered in the output register, which also holds it while o_out is stalled.
// A new tick is taken in the same cycle as the held result leaves.
// Config writes are always accepted (ready is always high).
// Synchronous active-low reset returns to idle with min all ones, max and average zero.
module spi_adc_averaging_reader import saar_pkg::*; #(
    parameter int DATA_BITS  = DATA_BITS_DEF,
    parameter int READS_LOG2 = READS_LOG2_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    saar_in_if.sink  i_in,
    saar_out_if.source o_out,
    saar_cfg_if.sink i_cfg
);

    localparam int WIDE_W = DATA_BITS + CODE_W;

    logic [HALF_W-1:0]  r_half;
    logic [DUMMY_W-1:0] r_dummy;
    logic               r_valid;
    logic               r_cs_n, r_sclk, r_busy, r_done;
    logic [CODE_W-1:0]  r_avg, r_min, r_max;

    logic                 step;
    t_seq_ev              ev;
    logic [DATA_BITS-1:0] avg, min_v, max_v;
    logic [WIDE_W-1:0]    avg_w, min_w, max_w;

    assign i_in.ready  = !r_valid || o_out.ready;
    assign step        = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    saar_seq #(.DATA_BITS(DATA_BITS), .READS_LOG2(READS_LOG2)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_start_req  (i_in.start_req),
        .i_half_period(r_half),
        .i_dummy      (r_dummy),
        .o_ev         (ev)
    );

    saar_stats #(.DATA_BITS(DATA_BITS), .READS_LOG2(READS_LOG2)) u_stats (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ev   (ev),
        .i_miso (i_in.miso),
        .o_avg  (avg),
        .o_min  (min_v),
        .o_max  (max_v)
    );

    assign avg_w = {{CODE_W{1'b0}}, avg};
    assign min_w = {{CODE_W{1'b0}}, min_v};
    assign max_w = {{CODE_W{1'b0}}, max_v};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_RESET;
            r_dummy <= DUMMY_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_HALF_PERIOD: r_half  <= i_cfg.data;
                REG_DUMMY:       r_dummy <= i_cfg.data[DUMMY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_cs_n <= ev.cs_n;
            r_sclk <= ev.sclk;
            r_busy <= ev.busy;
            r_done <= ev.meas_end;
            r_avg  <= avg_w[CODE_W-1:0];
            r_min  <= min_w[CODE_W-1:0];
            r_max  <= max_w[CODE_W-1:0];
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.chip_select_n = r_cs_n;
    assign o_out.serial_clock  = r_sclk;
    assign o_out.busy_res      = r_busy;
    assign o_out.done_res      = r_done;
    assign o_out.average_code  = r_avg;
    assign o_out.min_code      = r_min;
    assign o_out.max_code      = r_max;

endmodule

@@ sv/saar_chk.sv @@
// Port-level checker for the SPI ADC averaging reader, bound to the top level.
module saar_chk import saar_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_cs_n,
    input logic              i_sclk,
    input logic              i_busy,
    input logic              i_done,
    input logic [CODE_W-1:0] i_avg,
    input logic [CODE_W-1:0] i_min,
    input logic [CODE_W-1:0] i_max
);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> !i_busy && i_cs_n && i_sclk)
        else $error("done shown while busy or pins active");

    a_cs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_cs_n |-> i_busy)
        else $error("chip select low outside a measurement");

    a_sclk_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_sclk |-> !i_cs_n)
        else $error("serial clock low with chip select high");

    a_done_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> i_min <= i_avg && i_avg <= i_max)
        else $error("average outside min/max after done");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_avg) && $stable(i_done)
            && $stable(i_cs_n) && $stable(i_sclk))
        else $error("stalled result changed");

endmodule

bind spi_adc_averaging_reader saar_chk u_saar_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_cs_n     (o_out.chip_select_n),
    .i_sclk     (o_out.serial_clock),
    .i_busy     (o_out.busy_res),
    .i_done     (o_out.done_res),
    .i_avg      (o_out.average_code),
    .i_min      (o_out.min_code),
    .i_max      (o_out.max_code)
);
